// ----- rtl/core/btmx_pkg.sv -----
package btmx_pkg;

    // Default sizing
    localparam int KEY_BITS_DEF   = 31;
    localparam int NODE_COUNT_DEF = 16384;
    localparam int COUNT_BITS_DEF = 16;

    // Operation codes (s_tuser)
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    // Result codes (m_tuser)
    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_POOL_FULL  = 3'd1,
        STATUS_KEY_ABSENT = 3'd2,
        STATUS_SET_EMPTY  = 3'd3,
        STATUS_COUNT_OVF  = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE,
        ST_QUERY,
        ST_RESP
    } state_t;

endpackage

// ----- rtl/core/binary_trie_max_xor_multiset_top.sv -----
// Channel  Ports                    Contents (lowest bit up)
// -------  -----------------------  ----------------------------------------------
// input    s_tvalid/s_tready        s_tuser: func[1:0]; s_tdata: key, zero padded
// result   m_tvalid/m_tready        m_tuser: status[2:0]; m_tdata: best_xor, padded
//
// One transaction in flight; each tree level costs one read of the node memory.
// Insert/remove: a check walk down the key's path, then an update walk that writes each level back.
// Query: a greedy walk down from the root, stopping early at a missing child; unused func: straight to the response.
// After reset a pass writes the zero-key path; s_tready stays low meanwhile.
// A waiting result in the output register does not block the next input
// transaction; a finished walk holds in ST_RESP until the output register frees.
module binary_trie_max_xor_multiset_top
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((KEY_BITS+7)/8)*8-1:0]     s_tdata,   // key
    input  logic [1:0]                        s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((KEY_BITS+7)/8)*8-1:0]     m_tdata,   // best_xor
    output logic [2:0]                        m_tuser    // status
);

    localparam int DATA_W    = ((KEY_BITS + 7) / 8) * 8;
    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int FREE_W    = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int ENTRY_W   = 2 * NODE_BITS + 2 * COUNT_BITS;
    localparam int CNT_OFS   = 2 * NODE_BITS;
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(KEY_BITS - 1);

    // Node entry: {cnt1, cnt0, link1, link0}; a child's use count lives in its parent.
    logic [ENTRY_W-1:0]   node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LEVEL_W-1:0]   init_cnt_reg, init_cnt_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    func_t                func_reg, func_next;
    logic                 fresh_reg, fresh_next;
    logic [FREE_W-1:0]    next_free_reg, next_free_next;
    logic [KEY_BITS-1:0]  acc_reg, acc_next;
    status_t              status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;

    // Decoded view of the current node
    logic [ENTRY_W-1:0]    cur_entry;
    logic [NODE_BITS-1:0]  cur_link [2];
    logic [COUNT_BITS-1:0] cur_cnt  [2];
    logic                  bit_b;
    logic [NODE_BITS-1:0]  link_same, link_opp;
    logic [COUNT_BITS-1:0] cnt_same, cnt_opp;
    logic                  at_bottom, at_top;
    logic [FREE_W:0]       pool_sum;
    logic                  pool_ok;
    logic                  q_empty, q_take_opp;
    logic [NODE_BITS-1:0]  q_next;
    logic                  alloc;
    logic [NODE_BITS-1:0]  upd_link;
    logic [COUNT_BITS-1:0] upd_cnt;
    logic [ENTRY_W-1:0]    upd_entry;
    logic [ENTRY_W-1:0]    init_entry;
    logic                  out_free;

    // Node memory, one write and one read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    // Field extraction and per-level decisions
    always_comb begin
        cur_entry = fresh_reg ? '0 : rd_data_reg;
        for (int i = 0; i < 2; i++) begin
            cur_link[i] = cur_entry[i*NODE_BITS +: NODE_BITS];
            cur_cnt[i]  = cur_entry[CNT_OFS + i*COUNT_BITS +: COUNT_BITS];
        end
        bit_b     = key_reg[level_reg];
        link_same = cur_link[bit_b];
        link_opp  = cur_link[~bit_b];
        cnt_same  = cur_cnt[bit_b];
        cnt_opp   = cur_cnt[~bit_b];
        at_bottom = (level_reg == '0);
        at_top    = (level_reg == LAST_LEVEL);

        // missing nodes from this level down: level + 1
        pool_sum = {1'b0, next_free_reg} + (FREE_W+1)'(level_reg) + (FREE_W+1)'(1);
        pool_ok  = (pool_sum <= (FREE_W+1)'(NODE_COUNT));

        q_empty    = ((cur_link[0] == '0) || (cur_cnt[0] == '0))
                  && ((cur_link[1] == '0) || (cur_cnt[1] == '0));
        q_take_opp = (link_opp != '0) && (cnt_opp != '0);
        q_next     = q_take_opp ? link_opp : link_same;

        // update walk: allocate a missing child, bump its count up on insert, down on remove
        alloc    = (link_same == '0);
        upd_link = alloc ? next_free_reg[NODE_BITS-1:0] : link_same;
        upd_cnt  = (func_reg == FUNC_INSERT) ? cnt_same + COUNT_BITS'(1)
                                             : cnt_same - COUNT_BITS'(1);
        upd_entry = cur_entry;
        upd_entry[bit_b*NODE_BITS +: NODE_BITS]             = upd_link;
        upd_entry[CNT_OFS + bit_b*COUNT_BITS +: COUNT_BITS] = upd_cnt;

        // zero-key path: link0 to the next node, count one
        init_entry = '0;
        init_entry[0 +: NODE_BITS] = NODE_BITS'(init_cnt_reg) + NODE_BITS'(1);
        init_entry[CNT_OFS +: COUNT_BITS] = COUNT_BITS'(1);

        out_free = !m_tvalid_reg || m_tready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (init_cnt_reg == LAST_LEVEL) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (func_t'(s_tuser))
                        FUNC_INSERT, FUNC_REMOVE: state_next = ST_CHECK;
                        FUNC_QUERY:               state_next = ST_QUERY;
                        default:                  state_next = ST_RESP;
                    endcase
                end
            end
            ST_CHECK: begin
                if (func_reg == FUNC_INSERT) begin
                    if (link_same == '0) begin
                        state_next = pool_ok ? ST_UPDATE : ST_RESP;
                    end else if (&cnt_same) begin
                        state_next = ST_RESP;
                    end else if (at_bottom) begin
                        state_next = ST_UPDATE;
                    end
                end else begin
                    if ((link_same == '0) || (cnt_same == '0)) begin
                        state_next = ST_RESP;
                    end else if (at_bottom) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (at_bottom) state_next = ST_RESP;
            end
            ST_QUERY: begin
                if ((at_top && q_empty) || at_bottom || (q_next == '0)) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = node_reg;
        wr_data        = upd_entry;
        level_next     = level_reg;
        init_cnt_next  = init_cnt_reg;
        node_next      = node_reg;
        key_next       = key_reg;
        func_next      = func_reg;
        fresh_next     = fresh_reg;
        next_free_next = next_free_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        unique case (state_reg)
            ST_INIT: begin
                wr_en         = 1'b1;
                wr_addr       = NODE_BITS'(init_cnt_reg);
                wr_data       = init_entry;
                init_cnt_next = init_cnt_reg + LEVEL_W'(1);
            end
            ST_IDLE: begin
                // root read issued here, lands at the first walk cycle
                key_next    = s_tdata[KEY_BITS-1:0];
                func_next   = func_t'(s_tuser);
                level_next  = LAST_LEVEL;
                node_next   = '0;
                fresh_next  = 1'b0;
                acc_next    = '0;
                status_next = STATUS_OK;
            end
            ST_CHECK: begin
                if (func_reg == FUNC_INSERT) begin
                    if (link_same == '0) begin
                        if (!pool_ok) status_next = STATUS_POOL_FULL;
                        level_next = LAST_LEVEL;
                        node_next  = '0;
                    end else if (&cnt_same) begin
                        status_next = STATUS_COUNT_OVF;
                    end else if (at_bottom) begin
                        level_next = LAST_LEVEL;
                        node_next  = '0;
                    end else begin
                        node_next  = link_same;
                        rd_addr    = link_same;
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end else begin
                    if ((link_same == '0) || (cnt_same == '0)) begin
                        status_next = STATUS_KEY_ABSENT;
                    end else if (at_bottom) begin
                        level_next = LAST_LEVEL;
                        node_next  = '0;
                    end else begin
                        node_next  = link_same;
                        rd_addr    = link_same;
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end
            end
            ST_UPDATE: begin
                wr_en      = 1'b1;
                fresh_next = alloc;
                if (alloc) next_free_next = next_free_reg + FREE_W'(1);
                if (!at_bottom) begin
                    node_next  = upd_link;
                    rd_addr    = upd_link;
                    level_next = level_reg - LEVEL_W'(1);
                end
            end
            ST_QUERY: begin
                if (at_top && q_empty) begin
                    status_next = STATUS_SET_EMPTY;
                end else begin
                    acc_next[level_reg] = q_take_opp;
                    if (!at_bottom && (q_next != '0)) begin
                        node_next  = q_next;
                        rd_addr    = q_next;
                        level_next = level_reg - LEVEL_W'(1);
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = DATA_W'(acc_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            next_free_reg <= FREE_W'(KEY_BITS + 1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            next_free_reg <= next_free_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        level_reg   <= level_next;
        node_reg    <= node_next;
        key_reg     <= key_next;
        func_reg    <= func_next;
        fresh_reg   <= fresh_next;
        acc_reg     <= acc_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // allocation never runs past the pool
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= FREE_W'(NODE_COUNT))
        else $error("node pool pointer beyond pool size");

    // nodes are only allocated by the update walk
    a_alloc_only_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(next_free_reg))
        else $error("pool pointer moved outside update walk");

    // write-back and child read never hit the same entry mid-walk
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && level_reg != '0) |-> (wr_addr != rd_addr))
        else $error("read and write of the same node in one cycle");

    // the update walk descends one level per cycle
    a_update_descends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && state_next == ST_UPDATE)
            |=> (level_reg == $past(level_reg) - LEVEL_W'(1)))
        else $error("update walk skipped a level");

    // a pending result is never overwritten by the next one
    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && m_tvalid_reg && !m_tready) |=> (state_reg == ST_RESP))
        else $error("result left response state while output busy");
`endif

endmodule

// ----- sim/max_xor_trie_monitor.sv -----
module max_xor_trie_monitor
    import btmx_pkg::*;
#(
    parameter int DW = ((KEY_BITS_DEF + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [DW-1:0] s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [DW-1:0] m_tdata,
    input  logic [2:0]    m_tuser,
    output int            fail_count,
    output int            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB = KEY_BITS_DEF;
    localparam int NC = NODE_COUNT_DEF;
    localparam int CB = COUNT_BITS_DEF;
    localparam logic [CB-1:0] CNT_MAX = '1;

    typedef struct {
        func_t         op;
        logic [KB-1:0] key;
        status_t       status;
        logic [KB-1:0] best;
    } xor_reply_t;

    // Shadow trie: child links (0 = no child) and per-node use counts
    int unsigned   kid [NC][2];
    logic [CB-1:0] hits [NC];
    int unsigned   free_idx;

    xor_reply_t    replies_due[$];

    // Post-reset contents: key zero stored once
    function automatic void trie_clear();
        int i;
        for (i = 0; i < NC; i++) begin
            kid[i][0] = 0;
            kid[i][1] = 0;
            hits[i]   = '0;
        end
        for (i = 0; i < KB; i++) begin
            kid[i][0]  = i + 1;
            hits[i+1]  = CB'(1);
        end
        free_idx = KB + 1;
    endfunction

    function automatic status_t trie_insert(logic [KB-1:0] key);
        int          lvl;
        int unsigned node;
        int unsigned nxt;
        int unsigned needed;
        node   = 0;
        needed = 0;
        // dry walk: saturation is checked before pool space
        for (lvl = KB - 1; lvl >= 0; lvl--) begin
            nxt = kid[node][key[lvl]];
            if (nxt == 0) begin
                needed = lvl + 1;
                break;
            end
            if (hits[nxt] == CNT_MAX)
                return STATUS_COUNT_OVF;
            node = nxt;
        end
        if (free_idx + needed > NC)
            return STATUS_POOL_FULL;
        node = 0;
        for (lvl = KB - 1; lvl >= 0; lvl--) begin
            nxt = kid[node][key[lvl]];
            if (nxt == 0) begin
                nxt = free_idx;
                free_idx++;
                kid[nxt][0] = 0;
                kid[nxt][1] = 0;
                hits[nxt]   = '0;
                kid[node][key[lvl]] = nxt;
            end
            hits[nxt] = hits[nxt] + 1'b1;
            node = nxt;
        end
        return STATUS_OK;
    endfunction

    function automatic status_t trie_remove(logic [KB-1:0] key);
        int          lvl;
        int unsigned node;
        int unsigned nxt;
        node = 0;
        for (lvl = KB - 1; lvl >= 0; lvl--) begin
            nxt = kid[node][key[lvl]];
            if (nxt == 0 || hits[nxt] == 0)
                return STATUS_KEY_ABSENT;
            node = nxt;
        end
        node = 0;
        for (lvl = KB - 1; lvl >= 0; lvl--) begin
            nxt = kid[node][key[lvl]];
            hits[nxt] = hits[nxt] - 1'b1;
            node = nxt;
        end
        return STATUS_OK;
    endfunction

    // Greedy walk toward the opposite bit wherever a live child exists
    function automatic status_t trie_best_xor(logic [KB-1:0] key,
                                              output logic [KB-1:0] best);
        int          lvl;
        int unsigned node;
        int unsigned opp;
        int unsigned same;
        int unsigned c0;
        int unsigned c1;
        best = '0;
        c0   = kid[0][0];
        c1   = kid[0][1];
        if ((c0 == 0 || hits[c0] == 0) && (c1 == 0 || hits[c1] == 0))
            return STATUS_SET_EMPTY;
        node = 0;
        for (lvl = KB - 1; lvl >= 0; lvl--) begin
            opp = kid[node][key[lvl] ^ 1'b1];
            if (opp != 0 && hits[opp] != 0) begin
                best[lvl] = 1'b1;
                node = opp;
            end else begin
                same = kid[node][key[lvl]];
                if (same == 0)
                    break;
                node = same;
            end
        end
        return STATUS_OK;
    endfunction

    function automatic void trie_apply(ref xor_reply_t r);
        r.best   = '0;
        r.status = STATUS_OK;
        case (r.op)
            FUNC_INSERT: r.status = trie_insert(r.key);
            FUNC_REMOVE: r.status = trie_remove(r.key);
            FUNC_QUERY:  r.status = trie_best_xor(r.key, r.best);
            default:     r.status = STATUS_OK;
        endcase
    endfunction

    // Result transactions are checked before the same edge's input transaction
    always @(posedge aclk) begin
        xor_reply_t want;
        xor_reply_t seen;
        if (!aresetn) begin
            trie_clear();
            replies_due.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result status=%0d best_xor=%h",
                             $time, m_tuser, m_tdata[KB-1:0]);
                end else begin
                    want = replies_due.pop_front();
                    seen.status = status_t'(m_tuser);
                    seen.best   = m_tdata[KB-1:0];
                    if (seen.status !== want.status) begin
                        fail_count++;
                        $display("%0t: %s key=%h status expected %0d actual %0d",
                                 $time, want.op.name(), want.key, want.status, m_tuser);
                    end
                    if (seen.best !== want.best) begin
                        fail_count++;
                        $display("%0t: %s key=%h best_xor expected %h actual %h",
                                 $time, want.op.name(), want.key, want.best, seen.best);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.op  = func_t'(s_tuser);
                want.key = s_tdata[KB-1:0];
                trie_apply(want);
                replies_due = {replies_due, want};
            end
        end
        pending_count = replies_due.size();
    end

endmodule

// ----- sim/tb_binary_trie_max_xor_multiset_top.sv -----
module tb_binary_trie_max_xor_multiset_top
    import btmx_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB = KEY_BITS_DEF;
    localparam int DW = ((KB + 7) / 8) * 8;
    localparam logic [KB-1:0] KEY_ONES = '1;

    // Receiver hold-off: long stall so the input side backs up
    localparam int HOLD_AT_1   = 60;
    localparam int HOLD_AT_2   = 700;
    localparam int HOLD_CYCLES = 400;

    // Random phases: mixed traffic, pool fill, traffic on a full pool
    localparam int MIXED_ITEMS = 100;
    localparam int FILL_ITEMS  = 740;
    localparam int FULL_ITEMS  = 60;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;   // key, zero padded
    logic [1:0]    s_tuser;   // func
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;   // best_xor, zero padded
    logic [2:0]    m_tuser;   // status

    int            fail_count;
    int            pending_count;
    int            rx_count;
    bit            send_steady;
    bit            recv_steady;
    logic [KB-1:0] live_keys[$];

    binary_trie_max_xor_multiset_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    max_xor_trie_monitor u_trie_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs
    initial begin
        #(10_000_000);
        $display("tb_binary_trie_max_xor_multiset_top: done, errors");
        $finish;
    end

    // Per-transaction wait drawn at random, with occasional runs of back-to-back traffic
    function automatic int draw_gap(ref bit steady);
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // Mostly uniform keys, now and then a corner pattern
    function automatic logic [KB-1:0] any_key();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(0, 15) != 0)
            return raw[KB-1:0];
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return KEY_ONES;
            2:       return 31'h5555_5555;
            3:       return 31'h2AAA_AAAA;
            4:       return 31'h0000_0001;
            default: return 31'h4000_0000;
        endcase
    endfunction

    // One input transaction; valid stays high across back-to-back items
    task automatic send_op(func_t op, logic [KB-1:0] key);
        int gap;
        gap = draw_gap(send_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= DW'(key);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic insert_key(logic [KB-1:0] key);
        live_keys = {live_keys, key};
        send_op(FUNC_INSERT, key);
    endtask

    // Random item; insert_pct / fresh_pct shape the mix
    task automatic random_op(int insert_pct, int fresh_pct);
        int            roll;
        int            idx;
        logic [KB-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            if (live_keys.size() == 0 || $urandom_range(0, 99) < fresh_pct)
                k = any_key();
            else
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            insert_key(k);
        end else if (roll < insert_pct + (99 - insert_pct) / 2) begin
            // remove: mostly a stored copy, sometimes a neighbor or noise
            roll = $urandom_range(0, 9);
            if (live_keys.size() != 0 && roll < 8) begin
                idx = $urandom_range(0, live_keys.size() - 1);
                k   = live_keys[idx];
                live_keys.delete(idx);
            end else if (live_keys.size() != 0 && roll == 8) begin
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                k = k ^ (KB'(1) << $urandom_range(0, 4));
            end else begin
                k = any_key();
            end
            send_op(FUNC_REMOVE, k);
        end else if (roll < 99) begin
            send_op(FUNC_QUERY, any_key());
        end else begin
            send_op(FUNC_NOP, any_key());
        end
    endtask

    // Result side: random ready gaps plus two long hold-offs
    initial begin
        int idle;
        m_tready    = 1'b0;
        rx_count    = 0;
        recv_steady = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            idle = draw_gap(recv_steady);
            if (rx_count == HOLD_AT_1 || rx_count == HOLD_AT_2)
                idle = HOLD_CYCLES;
            if (idle > 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            rx_count++;
            @(negedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_NOP;
        send_steady = 1'b0;
        aresetn     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: the reset copy of zero, extremes, absent keys, empty set
        send_op(FUNC_QUERY, '0);
        send_op(FUNC_QUERY, KEY_ONES);
        send_op(FUNC_INSERT, KEY_ONES);
        send_op(FUNC_QUERY, '0);
        send_op(FUNC_INSERT, '0);
        send_op(FUNC_REMOVE, 31'h5555_5555);   // path never built
        send_op(FUNC_REMOVE, KEY_ONES);
        send_op(FUNC_REMOVE, KEY_ONES);        // path exists, counts zero
        send_op(FUNC_REMOVE, '0);
        send_op(FUNC_REMOVE, '0);
        send_op(FUNC_REMOVE, '0);              // nothing left
        send_op(FUNC_QUERY, 31'h2AAA_AAAA);    // empty set
        send_op(FUNC_NOP, KEY_ONES);
        send_op(FUNC_NOP, '0);
        insert_key(31'h4000_0000);
        insert_key(31'h0000_0001);
        insert_key(31'h2AAA_AAAA);
        insert_key(31'h5555_5555);
        send_op(FUNC_QUERY, KEY_ONES);
        send_op(FUNC_QUERY, '0);
        send_op(FUNC_QUERY, 31'h5555_5555);
        send_op(FUNC_REMOVE, 31'h4000_0001);   // shares all but the last level
        send_op(FUNC_QUERY, 31'h3FFF_FFFF);

        // random: mixed traffic, then mostly fresh inserts until the pool
        // runs out, then mixed traffic against a full pool
        repeat (MIXED_ITEMS) random_op(35, 50);
        repeat (FILL_ITEMS) random_op(97, 100);
        repeat (FULL_ITEMS) random_op(35, 30);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);

        if (fail_count == 0)
            $display("tb_binary_trie_max_xor_multiset_top: done, clean");
        else
            $display("tb_binary_trie_max_xor_multiset_top: done, errors");
        $finish;
    end

endmodule
